FILE: rtl/core/mbd_pkg.sv
`default_nettype none
package mbd_pkg;

  // Number of buttons the block keeps state for.
  localparam int BUTTONS = 4;

  // Fixed field widths.
  localparam int FUNC_W  = 2;
  localparam int RAW_W   = 4;
  localparam int TIME_W  = 32;
  localparam int BIDX_W  = 4;
  localparam int LVL_W   = 4;
  localparam int DEB_W   = 16;
  localparam int ACT_W   = 3;
  localparam int CFGI_W  = 2;
  localparam int CFGD_W  = 16;

  // Derived widths.
  localparam int IDX_W = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;
  localparam int CNT_W = $clog2(BUTTONS + 1);
  localparam int CMP_W = (CNT_W > BIDX_W) ? CNT_W : BIDX_W;

  // Item function codes.
  localparam logic [FUNC_W-1:0] FUNC_SAMPLE  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_PRESS   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_RELEASE = 2'd2;

  // Register indexes.
  localparam logic [CFGI_W-1:0] REG_SETTLE_MS      = 2'd0;
  localparam logic [CFGI_W-1:0] REG_ACTIVE_BUTTONS = 2'd1;

  // Reset values.
  localparam logic [DEB_W-1:0] DEBOUNCE_RESET = 16'd20;
  localparam logic [ACT_W-1:0] ACTIVE_RESET   = 3'd4;

  // Raw pin level meaning "pressed" (active-low buttons).
  localparam logic LEVEL_PRESSED = 1'b0;

endpackage : mbd_pkg
`default_nettype wire

FILE: rtl/core/mbd_item_if.sv
`default_nettype none
interface mbd_item_if
  import mbd_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [RAW_W-1:0]  raw_levels;
  logic [TIME_W-1:0] now_ms;
  logic [BIDX_W-1:0] button_index;

  modport source (output valid, func, raw_levels, now_ms, button_index, input ready);
  modport sink   (input valid, func, raw_levels, now_ms, button_index, output ready);
endinterface : mbd_item_if
`default_nettype wire

FILE: rtl/core/mbd_result_if.sv
`default_nettype none
interface mbd_result_if
  import mbd_pkg::*;
();
  logic             valid;
  logic             ready;
  logic             flag;
  logic [LVL_W-1:0] stable_levels;

  modport source (output valid, flag, stable_levels, input ready);
  modport sink   (input valid, flag, stable_levels, output ready);
endinterface : mbd_result_if
`default_nettype wire

FILE: rtl/core/multi_button_debouncer.sv
// Debouncer for a row of active-low push buttons with sticky press/release events.
//
// Channels (valid/ready, transfer when both high):
//   item   : func, raw_levels, now_ms, button_index. A sample (func 0) feeds the raw
//            pin levels and the millisecond tick; func 1 / 2 read and clear one button's
//            press / release flag. Other codes change nothing.
//   result : one transfer per item: flag (queried flag before clearing, else 0) and
//            stable_levels (debounced levels after the item).
//   cfg    : cfg_we / cfg_index / cfg_data, register 0 settle time (ms), 1 active_buttons.
//            Write only while the block is idle.
// Timing: a sample walks the active buttons one per cycle through a single shared
//   subtract/compare unit and then loads its result; a query loads its result
//   directly. Ready returns together with the load, so items are taken one at a
//   time, and a new item can transfer even while the loaded result still waits.
// Stall: if the result register is still full when an item finishes, the sequencer
//   holds in its final state until the receiver takes the old result.
// Reset (rst, synchronous): stable and previous levels go to released (1), timers and
//   flags clear, settle time = 20 ms, active_buttons = 4, result channel empty.
`default_nettype none
module multi_button_debouncer
  import mbd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [CFGI_W-1:0] cfg_index,
  input  wire logic [CFGD_W-1:0] cfg_data,
  mbd_item_if.sink               item,
  mbd_result_if.source           result
);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} state_t;

  state_t state;

  // config
  logic [DEB_W-1:0] settle_ms;
  logic [ACT_W-1:0] active_buttons;

  // per-button state
  logic [BUTTONS-1:0] stable_level;
  logic [BUTTONS-1:0] previous_sample;
  logic [BUTTONS-1:0] press_flag;
  logic [BUTTONS-1:0] release_flag;
  logic [TIME_W-1:0]  change_time [BUTTONS];

  // latched sample
  logic [RAW_W-1:0]  raw_r;
  logic [TIME_W-1:0] now_r;
  logic              flag_r;
  logic [IDX_W-1:0]  cnt;

  // output register
  logic             out_valid;
  logic             out_flag;
  logic [LVL_W-1:0] out_levels;

  // combinational
  logic [CMP_W-1:0]   live_n;
  logic [BUTTONS-1:0] raw_ext;
  logic [LVL_W-1:0]   levels_now;
  logic               lvl;
  logic [TIME_W-1:0]  t_start;
  logic [TIME_W-1:0]  elapsed;
  logic               settled;
  logic               flip;
  logic               last_btn;
  logic               q_in_range;
  logic [IDX_W-1:0]   q_sel;

  always_ff @(posedge clk) begin
    if (rst) begin
      settle_ms      <= DEBOUNCE_RESET;
      active_buttons <= ACTIVE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SETTLE_MS:      settle_ms      <= cfg_data[DEB_W-1:0];
        REG_ACTIVE_BUTTONS: active_buttons <= cfg_data[ACT_W-1:0];
        default: ;
      endcase
    end
  end

  // active count, saturated at BUTTONS
  always_comb begin
    if (CMP_W'(active_buttons) > CMP_W'(BUTTONS)) begin
      live_n = CMP_W'(BUTTONS);
    end else begin
      live_n = CMP_W'(active_buttons);
    end
  end

  // buttons beyond the raw field read as 0; levels above BUTTONS report 0
  always_comb begin
    for (int b = 0; b < BUTTONS; b++) begin
      raw_ext[b] = (b < RAW_W) ? raw_r[b % RAW_W] : 1'b0;
    end
    for (int b = 0; b < LVL_W; b++) begin
      levels_now[b] = (b < BUTTONS) ? stable_level[b % BUTTONS] : 1'b0;
    end
  end

  // shared timer unit: one button per cycle
  assign lvl      = raw_ext[cnt];
  assign t_start  = (lvl != previous_sample[cnt]) ? now_r : change_time[cnt];
  assign elapsed  = now_r - t_start;
  assign settled  = elapsed > TIME_W'(settle_ms);
  assign flip     = settled && (lvl != stable_level[cnt]);
  assign last_btn = (CMP_W'(cnt) + CMP_W'(1)) == live_n;

  assign q_in_range = CMP_W'(item.button_index) < live_n;
  assign q_sel      = IDX_W'(item.button_index);

  assign item.ready           = (state == S_IDLE);
  assign result.valid         = out_valid;
  assign result.flag          = out_flag;
  assign result.stable_levels = out_levels;

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      out_valid       <= 1'b0;
      cnt             <= '0;
      stable_level    <= '1;
      previous_sample <= '1;
      press_flag      <= '0;
      release_flag    <= '0;
      for (int b = 0; b < BUTTONS; b++) begin
        change_time[b] <= '0;
      end
    end else begin
      // S_DONE either keeps or reloads the register, so it never clears here
      if (out_valid && result.ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (item.valid) begin
            raw_r <= item.raw_levels;
            now_r <= item.now_ms;
            cnt   <= '0;
            case (item.func)
              FUNC_SAMPLE: begin
                flag_r <= 1'b0;
                state  <= (live_n != '0) ? S_SCAN : S_DONE;
              end
              FUNC_PRESS: begin
                flag_r <= q_in_range && press_flag[q_sel];
                state  <= S_DONE;
                if (q_in_range) begin
                  press_flag[q_sel] <= 1'b0;
                end
              end
              FUNC_RELEASE: begin
                flag_r <= q_in_range && release_flag[q_sel];
                state  <= S_DONE;
                if (q_in_range) begin
                  release_flag[q_sel] <= 1'b0;
                end
              end
              default: begin
                flag_r <= 1'b0;
                state  <= S_DONE;
              end
            endcase
          end
        end
        S_SCAN: begin
          change_time[cnt]     <= t_start;
          previous_sample[cnt] <= lvl;
          if (flip) begin
            stable_level[cnt] <= lvl;
            if (lvl == LEVEL_PRESSED) begin
              press_flag[cnt] <= 1'b1;
            end else begin
              release_flag[cnt] <= 1'b1;
            end
          end
          if (last_btn) begin
            state <= S_DONE;
          end else begin
            cnt <= cnt + IDX_W'(1);
          end
        end
        S_DONE: begin
          // load result once the register is free
          if (!out_valid || result.ready) begin
            out_valid  <= 1'b1;
            out_flag   <= flag_r;
            out_levels <= levels_now;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule : multi_button_debouncer
`default_nettype wire
